@@ design/pldt_pkg.sv @@
// Shared codes and types for the page loaded/dirty tracker.
// No dependencies; imported by page_loaded_dirty_tracker.
`default_nettype none

package pldt_pkg;

  // operation codes on mode_i
  localparam logic [2:0] MODE_QUERY  = 3'd0;
  localparam logic [2:0] MODE_ENSURE = 3'd1;
  localparam logic [2:0] MODE_DIRTY  = 3'd2;
  localparam logic [2:0] MODE_LOADED = 3'd3;
  localparam logic [2:0] MODE_FLUSH  = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_LOAD   = 2'd1;
  localparam logic [1:0] KIND_WRITE  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ABSENT    = 2'd1;
  localparam logic [1:0] ST_BAD       = 2'd2;
  localparam logic [1:0] ST_NOHANDLER = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_TRACK   = 2'd0;
  localparam logic [1:0] REG_PCOUNT  = 2'd1;
  localparam logic [1:0] REG_PSHIFT  = 2'd2;
  localparam logic [1:0] REG_HANDLER = 2'd3;

  localparam logic [4:0] SHIFT_MIN = 5'd9;
  localparam logic [4:0] SHIFT_MAX = 5'd16;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [31:0] start;
    logic [31:0] len;
    logic        last;
  } res_t;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_DEC   = 10'b0000000010,
    ST_CHK   = 10'b0000000100,
    ST_WALK  = 10'b0000001000,
    ST_WTAIL = 10'b0000010000,
    ST_RESP  = 10'b0000100000,
    ST_SCAN  = 10'b0001000000,
    ST_FTAIL = 10'b0010000000,
    ST_FEND  = 10'b0100000000,
    ST_FOUT  = 10'b1000000000
  } state_e;

endpackage

`default_nettype wire

@@ design/page_loaded_dirty_tracker.sv @@
// Top level of the page loaded/dirty tracker: sequencer plus page state memory.
// Depends on pldt_pkg.
`default_nettype none

// One item is in work at a time; busy_o is high from the accepting edge until
// the item's last result has been formed. Page state lives in a memory of
// {loaded, dirty} pairs with a registered read, walked one page per cycle
// with read-modify-write. Items that fail early (bad mode, tracking off,
// flush without handler, empty range) end in decode and a bad range in the
// range check. A flush scans every tracked page and issues one write-back per
// run of dirty pages. Results come out as one-cycle strobes on res_valid_o, in
// the cycle after they are formed; they cannot be held off, so the receiver
// must take every transfer. Reset marks every page not loaded and clean at
// once through per-page valid flags; no clearing pass.
module page_loaded_dirty_tracker import pldt_pkg::*; #(
  parameter int MAX_PAGES = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  mode_i,
  input  wire logic [31:0] pos_i,
  input  wire logic [31:0] len_i,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [6:0]  cfg_wdata_i,
  output logic             res_valid_o,
  output logic [1:0]       kind_o,
  output logic [1:0]       status_o,
  output logic [31:0]      req_base_o,
  output logic [31:0]      range_len_o,
  output logic             last_o
);

  localparam int IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CNT_W = $clog2(MAX_PAGES + 1);
  localparam logic [6:0] MAXP = 7'(MAX_PAGES);

  // configuration
  logic       track_q, handler_q;
  logic [6:0] pcount_q;
  logic [4:0] pshift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_q   <= 1'b1;
      pcount_q  <= 7'd64;
      pshift_q  <= 5'd12;
      handler_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TRACK:   track_q   <= cfg_wdata_i[0];
        REG_PCOUNT:  pcount_q  <= cfg_wdata_i;
        REG_PSHIFT:  pshift_q  <= cfg_wdata_i[4:0];
        REG_HANDLER: handler_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  logic [6:0]       n7;
  logic [CNT_W-1:0] n;
  logic [4:0]       sh;

  assign n7 = (pcount_q > MAXP) ? MAXP : pcount_q;
  assign n  = CNT_W'(n7);
  always_comb begin
    if (pshift_q < SHIFT_MIN)      sh = SHIFT_MIN;
    else if (pshift_q > SHIFT_MAX) sh = SHIFT_MAX;
    else                           sh = pshift_q;
  end

  // page state memory: bit 1 loaded, bit 0 dirty
  logic [1:0]       mem_q [MAX_PAGES];
  logic [MAX_PAGES-1:0] vld_q;
  logic [1:0]       rdata_q;
  logic             rd_en, we;
  logic [1:0]       wdata;

  // sequencer registers
  state_e           state_q, state_d;
  logic [2:0]       op_q;
  logic [31:0]      pos_q, len_q;
  logic [32:0]      end_q, end_d;
  logic [IDX_W-1:0] first_q, first_d, lastp_q, lastp_d;
  logic [IDX_W-1:0] p_q, p_d, pa_q;
  logic             rv_q;
  logic             all_q, all_d;
  logic             in_run_q, in_run_d;
  logic [IDX_W-1:0] run_start_q, run_start_d;
  logic             pend_v_q, pend_v_d;
  logic [CNT_W-1:0] pend_start_q, pend_start_d, pend_len_q, pend_len_d;
  logic             res_valid_q, emit;
  res_t             res_q, res_d;

  logic [1:0]       entry;
  logic [32:0]      lastp_full;
  logic [31:0]      first_full;
  logic             close_run;
  logic [CNT_W-1:0] close_end;
  logic [CNT_W-1:0] load_pages;

  assign entry      = vld_q[pa_q] ? rdata_q : 2'b00;
  assign lastp_full = end_q >> sh;
  assign first_full = pos_q >> sh;
  assign load_pages = CNT_W'(lastp_q) - CNT_W'(first_q) + CNT_W'(1);

  always_comb begin
    state_d      = state_q;
    end_d        = end_q;
    first_d      = first_q;
    lastp_d      = lastp_q;
    p_d          = p_q;
    all_d        = all_q;
    in_run_d     = in_run_q;
    run_start_d  = run_start_q;
    pend_v_d     = pend_v_q;
    pend_start_d = pend_start_q;
    pend_len_d   = pend_len_q;
    rd_en        = 1'b0;
    we           = 1'b0;
    wdata        = entry;
    emit         = 1'b0;
    res_d        = '{kind: KIND_STATUS, status: ST_OK, start: '0, len: '0, last: 1'b1};
    close_run    = 1'b0;
    close_end    = CNT_W'(pa_q);

    // data of the page read last cycle
    if (rv_q) begin
      unique case (op_q)
        MODE_DIRTY: begin
          we    = 1'b1;
          wdata = {entry[1], 1'b1};
        end
        MODE_LOADED: begin
          we    = 1'b1;
          wdata = 2'b10;
        end
        MODE_FLUSH: begin
          if (entry[0]) begin
            we    = 1'b1;
            wdata = {entry[1], 1'b0};
            if (!in_run_q) begin
              in_run_d    = 1'b1;
              run_start_d = pa_q;
            end
          end else if (in_run_q) begin
            close_run = 1'b1;
          end
        end
        default: all_d = all_q & entry[1];
      endcase
    end

    unique case (state_q)
      ST_IDLE: ;
      ST_DEC: begin
        end_d = {1'b0, pos_q} + {1'b0, len_q} - 33'd1;
        if (op_q > MODE_FLUSH) begin
          emit = 1'b1;
          res_d.status = ST_BAD;
          state_d = ST_IDLE;
        end else if (!track_q || (op_q == MODE_FLUSH && !handler_q)
                     || (op_q != MODE_FLUSH && len_q == '0)) begin
          emit = 1'b1;
          state_d = ST_IDLE;
        end else if (op_q == MODE_FLUSH) begin
          in_run_d = 1'b0;
          pend_v_d = 1'b0;
          p_d      = '0;
          state_d  = (n == '0) ? ST_FOUT : ST_SCAN;
        end else begin
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        if (lastp_full >= 33'(n)) begin
          emit = 1'b1;
          res_d.status = ST_BAD;
          state_d = ST_IDLE;
        end else begin
          first_d = first_full[IDX_W-1:0];
          lastp_d = lastp_full[IDX_W-1:0];
          p_d     = first_full[IDX_W-1:0];
          all_d   = 1'b1;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        rd_en = 1'b1;
        p_d   = p_q + IDX_W'(1);
        if (p_q == lastp_q) state_d = ST_WTAIL;
      end
      ST_WTAIL: state_d = ST_RESP;
      ST_RESP: begin
        emit = 1'b1;
        state_d = ST_IDLE;
        if ((op_q == MODE_QUERY || op_q == MODE_ENSURE) && !all_q) begin
          if (op_q == MODE_QUERY) begin
            res_d.status = ST_ABSENT;
          end else if (!handler_q) begin
            res_d.status = ST_NOHANDLER;
          end else begin
            res_d.kind   = KIND_LOAD;
            res_d.status = ST_ABSENT;
            res_d.start  = 32'(first_q) << sh;
            res_d.len    = 32'(load_pages) << sh;
          end
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
        p_d   = p_q + IDX_W'(1);
        if (CNT_W'(p_q) == n - CNT_W'(1)) state_d = ST_FTAIL;
      end
      ST_FTAIL: state_d = ST_FEND;
      ST_FEND: begin
        // a run that reaches the last page closes here
        if (in_run_q) begin
          close_run = 1'b1;
          close_end = n;
        end
        state_d = ST_FOUT;
      end
      ST_FOUT: begin
        emit = 1'b1;
        state_d = ST_IDLE;
        if (pend_v_q) begin
          res_d.kind  = KIND_WRITE;
          res_d.start = 32'(pend_start_q) << sh;
          res_d.len   = 32'(pend_len_q) << sh;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // hold one finished run back so the final one can carry last
    if (close_run) begin
      in_run_d = 1'b0;
      if (pend_v_q) begin
        emit        = 1'b1;
        res_d.kind  = KIND_WRITE;
        res_d.start = 32'(pend_start_q) << sh;
        res_d.len   = 32'(pend_len_q) << sh;
        res_d.last  = 1'b0;
      end
      pend_v_d     = 1'b1;
      pend_start_d = CNT_W'(run_start_q);
      pend_len_d   = close_end - CNT_W'(run_start_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rv_q        <= 1'b0;
      in_run_q    <= 1'b0;
      pend_v_q    <= 1'b0;
      res_valid_q <= 1'b0;
      vld_q       <= '0;
    end else begin
      state_q     <= (state_q == ST_IDLE && start_i) ? ST_DEC : state_d;
      rv_q        <= rd_en;
      in_run_q    <= in_run_d;
      pend_v_q    <= pend_v_d;
      res_valid_q <= emit;
      if (we) vld_q[pa_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      op_q  <= mode_i;
      pos_q <= pos_i;
      len_q <= len_i;
    end
    end_q        <= end_d;
    first_q      <= first_d;
    lastp_q      <= lastp_d;
    p_q          <= p_d;
    all_q        <= all_d;
    run_start_q  <= run_start_d;
    pend_start_q <= pend_start_d;
    pend_len_q   <= pend_len_d;
    if (rd_en) pa_q <= p_q;
    if (emit) res_q <= res_d;
  end

  // memory ports: one registered read, one write
  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= mem_q[p_q];
    if (we) mem_q[pa_q] <= wdata;
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign res_valid_o   = res_valid_q;
  assign kind_o        = res_q.kind;
  assign status_o      = res_q.status;
  assign req_base_o    = res_q.start;
  assign range_len_o   = res_q.len;
  assign last_o        = res_q.last;

  // the final result of an item leaves the block idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.last |-> state_q == ST_IDLE)
    else $error("last result issued while item still in work");

  // read data only arrives during a page walk or scan
  a_rv_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> (state_q == ST_WALK || state_q == ST_WTAIL ||
              state_q == ST_SCAN || state_q == ST_FTAIL))
    else $error("page data outside walk or scan");

  // writes stay inside the tracked pages
  a_we_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> CNT_W'(pa_q) < n)
    else $error("page write beyond page count");

  // a write-back request always reports ok and a nonzero length
  a_wb_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.kind == KIND_WRITE |-> res_q.status == ST_OK && res_q.len != '0)
    else $error("malformed write-back request");

  // an item is accepted only when idle and then enters decode
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE && start_i |=> state_q == ST_DEC)
    else $error("accepted item did not enter decode");

endmodule

`default_nettype wire

@@ verif/page_tracker_check.sv @@
// Result checking for the page loaded/dirty tracker: watches the command, config and
// result ports, keeps its own page state and compares each result in order.
// Depends on pldt_pkg.
module page_tracker_check import pldt_pkg::*; #(
  parameter int MAX_PAGES = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        busy_i,
  input  wire logic [2:0]  mode_i,
  input  wire logic [31:0] pos_i,
  input  wire logic [31:0] len_i,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [6:0]  cfg_wdata_i,
  input  wire logic        res_valid_i,
  input  wire logic [1:0]  kind_i,
  input  wire logic [1:0]  status_i,
  input  wire logic [31:0] req_base_i,
  input  wire logic [31:0] range_len_i,
  input  wire logic        last_i,
  output int               fail_count_o,
  output int               outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [MAX_PAGES-1:0] loaded_pages;
  logic [MAX_PAGES-1:0] dirty_pages;
  logic                 track_on;
  logic [6:0]           page_cnt;
  logic [4:0]           page_sh;
  logic                 handler_on;

  res_t pending_results[$];
  int   fails;

  assign fail_count_o  = fails;
  assign outstanding_o = pending_results.size();

  function automatic int unsigned pages_tracked();
    return (page_cnt > MAX_PAGES) ? MAX_PAGES : page_cnt;
  endfunction

  function automatic int unsigned page_bits();
    if (page_sh < SHIFT_MIN) return SHIFT_MIN;
    if (page_sh > SHIFT_MAX) return SHIFT_MAX;
    return page_sh;
  endfunction

  task automatic push_status(input logic [1:0] st);
    res_t r;
    r = '0;
    r.kind = KIND_STATUS;
    r.status = st;
    r.last = 1'b1;
    pending_results.push_back(r);
  endtask

  // Write back every run of dirty pages below the tracked count and clean it; with no run, an ok status.
  task automatic flush_runs();
    res_t        runs[$];
    res_t        r;
    int unsigned sh, npg, pg, run_end;
    sh = page_bits();
    npg = pages_tracked();
    pg = 0;
    while (pg < npg) begin
      if (!dirty_pages[pg]) begin
        pg++;
      end else begin
        run_end = pg;
        while (run_end < npg && dirty_pages[run_end]) begin
          dirty_pages[run_end] = 1'b0;
          run_end++;
        end
        r = '0;
        r.kind = KIND_WRITE;
        r.status = ST_OK;
        r.start = pg << sh;
        r.len = (run_end - pg) << sh;
        runs.push_back(r);
        pg = run_end;
      end
    end
    if (runs.size() == 0) begin
      push_status(ST_OK);
    end else begin
      r = runs.pop_back();
      r.last = 1'b1;
      runs.push_back(r);
      foreach (runs[i]) pending_results.push_back(runs[i]);
    end
  endtask

  task automatic apply_op(input logic [2:0] mode, input logic [31:0] pos_v,
                          input logic [31:0] len_v);
    int unsigned sh, npg, first_pg, last_idx;
    logic [32:0] end_byte;
    logic [32:0] last_pg;
    bit          all_loaded;
    res_t        r;
    sh = page_bits();
    npg = pages_tracked();
    all_loaded = 1'b1;
    if (mode > MODE_FLUSH) begin
      push_status(ST_BAD);
    end else if (!track_on) begin
      push_status(ST_OK);
    end else if (mode == MODE_FLUSH) begin
      if (handler_on) flush_runs();
      else push_status(ST_OK);
    end else if (len_v == 0) begin
      push_status(ST_OK);
    end else begin
      // last byte is taken in 33 bits so a wrapping range stays out of bounds
      end_byte = {1'b0, pos_v} + {1'b0, len_v} - 33'd1;
      last_pg = end_byte >> sh;
      first_pg = pos_v >> sh;
      if (last_pg >= npg) begin
        push_status(ST_BAD);
      end else begin
        last_idx = 32'(last_pg);
        case (mode)
          MODE_QUERY, MODE_ENSURE: begin
            for (int p = first_pg; p <= last_idx; p++)
              if (!loaded_pages[p]) all_loaded = 1'b0;
            if (all_loaded) begin
              push_status(ST_OK);
            end else if (mode == MODE_QUERY) begin
              push_status(ST_ABSENT);
            end else if (!handler_on) begin
              push_status(ST_NOHANDLER);
            end else begin
              r = '0;
              r.kind = KIND_LOAD;
              r.status = ST_ABSENT;
              r.start = first_pg << sh;
              r.len = (last_idx - first_pg + 1) << sh;
              r.last = 1'b1;
              pending_results.push_back(r);
            end
          end
          MODE_DIRTY: begin
            for (int p = first_pg; p <= last_idx; p++) dirty_pages[p] = 1'b1;
            push_status(ST_OK);
          end
          default: begin
            for (int p = first_pg; p <= last_idx; p++) begin
              loaded_pages[p] = 1'b1;
              dirty_pages[p] = 1'b0;
            end
            push_status(ST_OK);
          end
        endcase
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      loaded_pages = '0;
      dirty_pages = '0;
      track_on = 1'b1;
      page_cnt = 7'd64;
      page_sh = 5'd12;
      handler_on = 1'b0;
      pending_results.delete();
      fails = 0;
    end else begin
      // compare first: the last result of one item may share an edge with the next transfer
      if (res_valid_i) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: kind %0d status %0d base 0x%0h len 0x%0h",
                 kind_i, status_i, req_base_i, range_len_i);
          fails++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(kind_i));
          check_field("status", 32'(want.status), 32'(status_i));
          check_field("req_base", want.start, req_base_i);
          check_field("range_len", want.len, range_len_i);
          check_field("last", 32'(want.last), 32'(last_i));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TRACK:   track_on = cfg_wdata_i[0];
          REG_PCOUNT:  page_cnt = cfg_wdata_i;
          REG_PSHIFT:  page_sh = cfg_wdata_i[4:0];
          REG_HANDLER: handler_on = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) apply_op(mode_i, pos_i, len_i);
    end
  end

endmodule

@@ verif/page_loaded_dirty_tracker_test.sv @@
// Top of the page loaded/dirty tracker regression: clock, reset, command and config
// stimulus, and the verdict. Depends on pldt_pkg, page_loaded_dirty_tracker and
// page_tracker_check.
module page_loaded_dirty_tracker_test import pldt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [2:0]  mode_i;
  logic [31:0] pos_i;
  logic [31:0] len_i;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [6:0]  cfg_wdata_i;
  logic        res_valid_o;
  logic [1:0]  kind_o;
  logic [1:0]  status_o;
  logic [31:0] req_base_o;
  logic [31:0] range_len_o;
  logic        last_o;

  int          fail_count;
  int          outstanding;
  int          sent_count;
  bit          no_idle;
  int unsigned cur_pages;
  int unsigned cur_shift;

  page_loaded_dirty_tracker #(.MAX_PAGES(64)) DUT (
    .clk_i, .rst_ni, .start_i, .busy_o, .mode_i, .pos_i, .len_i,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .res_valid_o, .kind_o, .status_o, .req_base_o, .range_len_o, .last_o
  );

  page_tracker_check #(.MAX_PAGES(64)) u_tracker_check (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .mode_i, .pos_i, .len_i,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .res_valid_i(res_valid_o), .kind_i(kind_o), .status_i(status_o),
    .req_base_i(req_base_o), .range_len_i(range_len_o), .last_i(last_o),
    .fail_count_o(fail_count), .outstanding_o(outstanding)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Offer one command and hold it until the transfer; start stays high afterwards so a
  // back-to-back command never lowers and raises it in the same step.
  task automatic send_op(input logic [2:0] m, input logic [31:0] p, input logic [31:0] l);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    mode_i <= m;
    pos_i <= p;
    len_i <= l;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sent_count++;
  endtask

  // Hold off until every expected result has come and the block is idle.
  task automatic drain();
    start_i <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0 || busy_o);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  // Upper data bits of the narrow registers carry noise; the block must drop them.
  task automatic set_config(input bit trk, input logic [6:0] cnt, input logic [4:0] sh,
                            input bit hnd);
    logic [6:0] junk;
    junk = 7'($urandom);
    write_reg(REG_TRACK, {junk[6:1], trk});
    write_reg(REG_PCOUNT, cnt);
    junk = 7'($urandom);
    write_reg(REG_PSHIFT, {junk[6:5], sh});
    write_reg(REG_HANDLER, {junk[5:0], hnd});
    cfg_we_i <= 1'b0;
    cur_pages = (cnt > 64) ? 64 : cnt;
    cur_shift = (sh < SHIFT_MIN) ? SHIFT_MIN : (sh > SHIFT_MAX) ? SHIFT_MAX : sh;
  endtask

  // Byte range inside the tracked pages, or the first 64 when none is tracked, mostly one to three pages long.
  task automatic pick_range(output logic [31:0] p, output logic [31:0] l);
    int unsigned n, first, room, span, off_a, off_b;
    n = (cur_pages == 0) ? 64 : cur_pages;
    first = $urandom_range(0, n - 1);
    room = n - first;
    if ($urandom_range(0, 7) == 0) span = $urandom_range(1, room);
    else span = $urandom_range(1, (room < 3) ? room : 3);
    off_a = $urandom_range(0, (1 << cur_shift) - 1);
    off_b = $urandom_range((span == 1) ? off_a : 0, (1 << cur_shift) - 1);
    p = (first << cur_shift) + off_a;
    l = ((first + span - 1) << cur_shift) + off_b - p + 1;
  endtask

  task automatic send_noise();
    logic [2:0]  m;
    logic [31:0] p;
    logic [31:0] l;
    int unsigned n;
    m = 3'($urandom_range(0, 7));
    n = (cur_pages == 0) ? 64 : cur_pages;
    case ($urandom_range(0, 3))
      0: begin
        p = $urandom;
        l = $urandom;
      end
      1: begin
        pick_range(p, l);
        l = '0;
      end
      2: begin
        // straddle the end of the tracked pages
        p = (n << cur_shift) - 1 - $urandom_range(0, 3);
        l = $urandom_range(1, 10);
      end
      default: pick_range(p, l);
    endcase
    send_op(m, p, l);
  endtask

  task automatic run_sequence();
    logic [31:0] p;
    logic [31:0] l;
    if ($urandom_range(0, 4) == 0) no_idle = !no_idle;
    pick_range(p, l);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        // ensure, then load and recheck now and then
        send_op(MODE_ENSURE, p, l);
        if ($urandom_range(0, 3) == 0) begin
          send_op(MODE_LOADED, p, l);
          send_op(MODE_ENSURE, p, l);
        end
      end
      3, 4: send_op(MODE_QUERY, p, l);
      5, 6: begin
        send_op(MODE_DIRTY, p, l);
        if ($urandom_range(0, 3) == 0) send_op(MODE_FLUSH, $urandom, $urandom);
      end
      7: send_op(MODE_FLUSH, $urandom, $urandom);
      default: send_noise();
    endcase
  endtask

  initial begin
    int phase_end;
    rst_ni = 1'b0;
    start_i = 1'b0;
    mode_i = '0;
    pos_i = '0;
    len_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    sent_count = 0;
    no_idle = 1'b0;
    cur_pages = 64;
    cur_shift = 12;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part on the reset settings: 64 pages of 4 KiB, no handler
    send_op(MODE_QUERY, 32'd0, 32'd0);
    send_op(MODE_QUERY, 32'd0, 32'd4096);
    send_op(MODE_ENSURE, 32'd0, 32'd1);
    send_op(3'd5, 32'd0, 32'd1);
    send_op(3'd6, 32'hFFFF_FFFF, 32'd0);
    send_op(3'd7, 32'd100, 32'd100);
    send_op(MODE_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(MODE_LOADED, 32'd0, 32'd4096);
    send_op(MODE_ENSURE, 32'd0, 32'd4096);
    send_op(MODE_DIRTY, 32'd4096, 32'd8192);
    send_op(MODE_DIRTY, 32'd20580, 32'd1);
    send_op(MODE_DIRTY, 32'd258048, 32'd4096);
    send_op(MODE_QUERY, 32'd262143, 32'd1);
    send_op(MODE_QUERY, 32'd262144, 32'd1);
    send_op(MODE_FLUSH, 32'd0, 32'd0);
    drain();
    set_config(1'b1, 7'd64, 5'd12, 1'b1);
    send_op(MODE_ENSURE, 32'd4000, 32'd8192);
    send_op(MODE_ENSURE, 32'd0, 32'd0);
    send_op(MODE_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(MODE_FLUSH, 32'd0, 32'd0);
    send_op(MODE_DIRTY, 32'd0, 32'hFFFF_FFFF);
    send_op(MODE_DIRTY, 32'd0, 32'd262144);
    send_op(MODE_FLUSH, 32'd0, 32'd0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_config(1'b1, 7'd64, 5'd9, 1'b1);
        1: set_config(1'b1, 7'd1, 5'd16, 1'b1);
        2: set_config(1'b0, 7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)),
                      1'($urandom_range(0, 1)));
        3: set_config(1'b1, 7'd0, 5'd12, 1'b1);
        4: set_config(1'b1, 7'd127, 5'd31, 1'b1);
        5: set_config(1'b1, 7'($urandom_range(1, 64)), 5'd0, 1'b0);
        default: set_config(1'b1, 7'($urandom_range(1, 64)), 5'($urandom_range(9, 16)),
                            1'($urandom_range(0, 1)));
      endcase
      if (ph == 0) begin
        // every other page dirty: the flush emits its longest train of write-backs
        for (int pg = 0; pg < 64; pg += 2) send_op(MODE_DIRTY, pg << cur_shift, 32'd1);
        send_op(MODE_FLUSH, 32'd0, 32'd0);
      end
      phase_end = sent_count + 51;
      while (sent_count < phase_end) run_sequence();
      drain();
    end

    repeat (80) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("page_loaded_dirty_tracker regression: pass");
    end else begin
      $display("page_loaded_dirty_tracker regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("page_loaded_dirty_tracker regression: fail");
    $finish;
  end

endmodule

@@ files.f @@
design/pldt_pkg.sv
design/page_loaded_dirty_tracker.sv
verif/page_tracker_check.sv
verif/page_loaded_dirty_tracker_test.sv
